// ===== rtl/bfh_pkg.sv =====
package bfh_pkg;

    // field and register widths
    localparam int HASH_W = 32;
    localparam int TB_W   = 11;
    localparam int SH_W   = 5;
    localparam int CHAR_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // slot = 8 * byte index + bit, so the byte index comes from hash >> 3
    localparam int BIT_SEL_W = 3;
    localparam int DVD_W     = HASH_W - BIT_SEL_W;
    localparam int STEP_CNT_W = $clog2(DVD_W + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_SHIFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUL_FACTOR  = 2'd3;

    // key operations
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    // request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [TB_W-1:0]   divisor;
    } t_mod_req;

    // status of the remainder unit
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TB_W-1:0]   rem;
    } t_mod_sts;

endpackage

// ===== rtl/bfh_key_if.sv =====
interface bfh_key_if;
    logic              valid;
    logic              ready;
    logic              func;
    logic signed [7:0] key_char;
    logic              last_char;

    modport source (output valid, func, key_char, last_char, input ready);
    modport sink   (input valid, func, key_char, last_char, output ready);
endinterface

// ===== rtl/bfh_res_if.sv =====
interface bfh_res_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, found, input ready);
    modport sink   (input valid, found, output ready);
endinterface

// ===== rtl/bfh_ram.sv =====
module bfh_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bfh_mod.sv =====
module bfh_mod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfh_pkg::t_mod_req i_req,
    output bfh_pkg::t_mod_sts o_sts
);
    import bfh_pkg::*;

    logic [STEP_CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]      r_dvd;
    logic [TB_W-1:0]       r_rem;
    logic [TB_W-1:0]       r_dvs;
    logic                  r_done;

    logic [TB_W:0]         trial;
    logic [TB_W:0]         diff;
    logic [TB_W-1:0]       n_rem;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[TB_W-1:0];
        end else begin
            n_rem = trial[TB_W-1:0];
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= STEP_CNT_W'(DVD_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == STEP_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;

    // done only once the steps have run out
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0))
        else $error("remainder done while still stepping");

    // a finished remainder is below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dvs != '0) |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

    // the step count never exceeds the dividend width
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= STEP_CNT_W'(DVD_W))
        else $error("remainder step count out of range");

endmodule

// ===== rtl/bloom_filter_three_hash.sv =====
// channel   dir  signals                               beat
// i_key     in   valid ready func key_char last_char   one key character
// o_res     out  valid ready found                     membership answer of a find key
// i_cfg_*   in   we idx data                           register write, no handshake
//
// a character that does not end its key passes the hash update, then the multiply-add
// the final character passes the same two steps, then the bit-serial remainder unit, shared by
//   the three hashes, runs for each hash in turn, then each of the three table bytes is read and
//   checked, and written back for an insert key; a find key then loads the answer register
// after reset all MAX_TABLE_BYTES table bytes are cleared while i_key.ready stays low
// a waiting answer holds the block only when the next find answer is ready to load
module bloom_filter_three_hash #(
    parameter int MAX_TABLE_BYTES = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bfh_key_if.sink                             i_key,
    bfh_res_if.source                           o_res,
    input  logic                                i_cfg_we,
    input  logic [bfh_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bfh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bfh_pkg::*;

    localparam int ADDR_W = (MAX_TABLE_BYTES > 1) ? $clog2(MAX_TABLE_BYTES) : 1;

    // sequencer states
    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ADD    = 3'd2;
    localparam logic [2:0] S_MSTART = 3'd3;
    localparam logic [2:0] S_MWAIT  = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_CHK    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam logic [1:0] K_FIRST = 2'd0;
    localparam logic [1:0] K_MID   = 2'd1;
    localparam logic [1:0] K_LAST  = 2'd2;

    // configuration registers
    logic [TB_W-1:0]   r_table_bytes;
    logic [SH_W-1:0]   r_rotate;
    logic [SH_W-1:0]   r_xor_shift;
    logic [HASH_W-1:0] r_mul;

    // sequencer and hash state
    logic [2:0]        r_state;
    logic [1:0]        r_k;
    logic [ADDR_W-1:0] r_clr;
    logic [HASH_W-1:0] r_h1, r_h2, r_h3, r_prod;
    logic [HASH_W-1:0] r_char;
    logic              r_func;
    logic              r_last;
    logic              r_all;
    logic [ADDR_W-1:0]    r_idx [3];
    logic [BIT_SEL_W-1:0] r_sb  [3];
    logic              r_out_valid;
    logic              r_found;

    logic [HASH_W-1:0]    char_ext;
    logic [2*HASH_W-1:0]  rot_wide;
    logic [HASH_W-1:0]    n_h1, n_h2;
    logic [TB_W-1:0]      used_bytes;
    logic [HASH_W-1:0]    hash_sel;
    logic [ADDR_W-1:0]    idx_sel;
    logic [BIT_SEL_W-1:0] sb_sel;
    logic [7:0]           rdata;
    logic                 slot_hit;
    logic                 out_free;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [7:0]           ram_wdata;

    t_mod_req mod_req;
    t_mod_sts mod_sts;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bytes <= TB_W'(1024);
            r_rotate      <= SH_W'(5);
            r_xor_shift   <= SH_W'(5);
            r_mul         <= HASH_W'(37);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TABLE_BYTES: r_table_bytes <= i_cfg_data[TB_W-1:0];
                CFG_ROTATE:      r_rotate      <= i_cfg_data[SH_W-1:0];
                CFG_XOR_SHIFT:   r_xor_shift   <= i_cfg_data[SH_W-1:0];
                CFG_MUL_FACTOR:  r_mul         <= i_cfg_data[HASH_W-1:0];
                default: ;
            endcase
        end
    end

    // character update of the rotate and shift-xor hashes
    always_comb begin
        char_ext = {{(HASH_W-CHAR_W){i_key.key_char[CHAR_W-1]}}, i_key.key_char};
        rot_wide = {r_h1, r_h1} << r_rotate;
        n_h1     = rot_wide[2*HASH_W-1:HASH_W] ^ char_ext;
        n_h2     = r_h2 ^ (r_h2 << r_xor_shift) ^ char_ext;
    end

    // bytes in use, clamped to 1..MAX_TABLE_BYTES
    always_comb begin
        if (r_table_bytes == '0) begin
            used_bytes = TB_W'(1);
        end else if (32'(r_table_bytes) > MAX_TABLE_BYTES) begin
            used_bytes = TB_W'(MAX_TABLE_BYTES);
        end else begin
            used_bytes = r_table_bytes;
        end
    end

    // hash and slot selection by the current step
    always_comb begin
        unique case (r_k)
            K_FIRST: begin
                hash_sel = r_h1;
                idx_sel  = r_idx[0];
                sb_sel   = r_sb[0];
            end
            K_MID: begin
                hash_sel = r_h2;
                idx_sel  = r_idx[1];
                sb_sel   = r_sb[1];
            end
            default: begin
                hash_sel = r_h3;
                idx_sel  = r_idx[2];
                sb_sel   = r_sb[2];
            end
        endcase
    end

    // request to the shared remainder unit
    always_comb begin
        mod_req.start    = (r_state == S_MSTART);
        mod_req.dividend = hash_sel[HASH_W-1:BIT_SEL_W];
        mod_req.divisor  = used_bytes;
    end

    bfh_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_sts   (mod_sts)
    );

    // slot bit 0 of a byte is its most significant bit
    assign slot_hit = rdata[~sb_sel];
    assign out_free = !r_out_valid || o_res.ready;

    // table memory writes: clearing pass, then the insert read-modify-write
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_sel;
        ram_wdata = rdata | (8'h80 >> sb_sel);
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else if (r_state == S_CHK && r_func == FUNC_INSERT) begin
            ram_we = 1'b1;
        end
    end

    bfh_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TABLE_BYTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (idx_sel),
        .o_rdata (rdata)
    );

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_k     <= K_FIRST;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(MAX_TABLE_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_key.valid) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_k     <= K_FIRST;
                    r_state <= r_last ? S_MSTART : S_IDLE;
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mod_sts.done) begin
                        if (r_k == K_LAST) begin
                            r_k     <= K_FIRST;
                            r_state <= S_RD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_k == K_LAST) begin
                        r_k     <= K_FIRST;
                        r_state <= (r_func == FUNC_FIND) ? S_OUT : S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // running hashes, cleared at reset and at the end of each key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1 <= '0;
            r_h2 <= '0;
            r_h3 <= '0;
        end else if (r_state == S_IDLE && i_key.valid) begin
            r_h1 <= n_h1;
            r_h2 <= n_h2;
        end else if (r_state == S_ADD) begin
            r_h3 <= r_prod + r_char;
        end else if (r_state == S_MWAIT && mod_sts.done && r_k == K_LAST) begin
            r_h1 <= '0;
            r_h2 <= '0;
            r_h3 <= '0;
        end
    end

    // beat capture and the registered product
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_key.valid) begin
            r_prod <= r_h3 * r_mul;
            r_char <= char_ext;
            r_func <= i_key.func;
            r_last <= i_key.last_char;
        end
    end

    // slot positions from the remainder unit
    always_ff @(posedge i_clk) begin
        if (r_state == S_MWAIT && mod_sts.done) begin
            unique case (r_k)
                K_FIRST: begin
                    r_idx[0] <= ADDR_W'(mod_sts.rem);
                    r_sb[0]  <= hash_sel[BIT_SEL_W-1:0];
                end
                K_MID: begin
                    r_idx[1] <= ADDR_W'(mod_sts.rem);
                    r_sb[1]  <= hash_sel[BIT_SEL_W-1:0];
                end
                default: begin
                    r_idx[2] <= ADDR_W'(mod_sts.rem);
                    r_sb[2]  <= hash_sel[BIT_SEL_W-1:0];
                end
            endcase
        end
    end

    // all-three-set accumulator for find keys
    always_ff @(posedge i_clk) begin
        if (r_state == S_MSTART) begin
            r_all <= 1'b1;
        end else if (r_state == S_CHK) begin
            r_all <= r_all & slot_hit;
        end
    end

    // answer register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_found <= r_all;
        end
    end

    assign i_key.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.found = r_found;

    // an answer appears only from the answer state
    a_answer_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("answer loaded outside the answer state");

    // no key beat is taken while the table is being cleared
    a_no_take_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_key.ready)
        else $error("key beat accepted during the clearing pass");

    // the remainder unit is never restarted while it steps
    a_mod_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_req.start |-> !mod_sts.busy)
        else $error("remainder unit started while busy");

    // table bits are only set by insert keys
    a_write_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != S_CLR) |-> (r_func == FUNC_INSERT))
        else $error("table written by a find key");

endmodule
